FILE: hw/rtl/nnad_pkg.sv
package nnad_pkg;

    // Number format and exponential table geometry
    localparam int FRAC_BITS   = 12;
    localparam int DATA_WIDTH  = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int SPAN_LOG2   = 4;

    localparam int TBL_LOG2 = $clog2(TABLE_DEPTH);
    localparam int ARG_BITS = FRAC_BITS + SPAN_LOG2;   // exp argument range [0,16)
    localparam int FRAC_IDX = ARG_BITS - TBL_LOG2;     // interpolation fraction bits
    localparam int EXP_W    = 33;                      // unsigned Q32, 1.0 included
    localparam int Q_W      = FRAC_BITS + 1;           // quotient bits, up to 1.0
    localparam int Y_W      = DATA_WIDTH + 2;          // internal result before clamp
    localparam int NUM_W    = 32 + FRAC_BITS + 2;      // dividend and remainder
    localparam int ONE      = 1 << FRAC_BITS;
    localparam int HALF     = 1 << (FRAC_BITS - 1);

    localparam logic [EXP_W-1:0] Q32_ONE = {1'b1, 32'b0};

    typedef enum logic [2:0] {
        FN_NULL  = 3'd0,
        FN_IDENT = 3'd1,
        FN_STEP  = 3'd2,
        FN_SIGM  = 3'd3,
        FN_TANH  = 3'd4,
        FN_RELU  = 3'd5,
        FN_GAUSS = 3'd6,
        FN_BAD   = 3'd7
    } func_t;

    // Item attributes that travel alongside the exp/divide datapath
    typedef struct packed {
        logic                   deriv;
        func_t                  code;
        logic                   neg;
        logic [DATA_WIDTH-1:0]  mag;
        logic signed [Y_W-1:0]  ybase;
    } side_t;

    typedef logic [EXP_W-1:0] exp_word_t;
    typedef exp_word_t exp_rom_t [0:TABLE_DEPTH];

    // exp(-16k/TABLE_DEPTH) in Q32: series for one step, then repeated products
    function automatic exp_rom_t exp_rom_build();
        exp_rom_t    rom;
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        logic [63:0] prod;
        step = (64'd1 << (32 + SPAN_LOG2)) / 64'(TABLE_DEPTH);
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        for (int n = 1; n < 40; n++)
        begin
            term = ((term * step) >> 32) / 64'(n);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        q      = sum;
        rom[0] = Q32_ONE;
        for (int k = 1; k <= TABLE_DEPTH; k++)
        begin
            prod   = 64'(rom[k-1]) * q + (64'd1 << 31);
            rom[k] = EXP_W'(prod >> 32);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = exp_rom_build();

endpackage

FILE: hw/rtl/nn_activation_and_derivative_top.sv
// Channel   Handshake                   Beat fields
// item      item_valid / item_stall     action, function_code, x
// result    result_valid / result_stall y, error
//
// One beat per cycle unless result stalls; stages: 3 exp table/interp,
// 1 divider setup, 13 restoring divider stages, 1 output register.
// The 13-stage divider for logistic and tanh sets the depth.
// Reset (rst_n low, async) empties every stage; the table is constant.
// A result stall holds the output and the contiguous full stages behind it;
// item_stall rises only when every stage is full and the result beat is stalled.
module nn_activation_and_derivative_top import nnad_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         action,
    input  logic [2:0]                   function_code,
    input  logic signed [DATA_WIDTH-1:0] x,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] y,
    output logic                         error
);

    logic           item_rdy;
    logic           exp_vld;
    logic           exp_rdy;
    exp_word_t      exp_e;
    side_t          exp_side;
    logic           div_vld;
    logic           div_rdy;
    logic [Q_W-1:0] div_m;
    side_t          div_side;

    assign item_stall = !item_rdy;

    // argument, table lookup and interpolation
    nnad_exp u_exp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (item_valid),
        .in_rdy        (item_rdy),
        .action        (action),
        .function_code (function_code),
        .x             (x),
        .out_vld       (exp_vld),
        .out_rdy       (exp_rdy),
        .e             (exp_e),
        .side          (exp_side)
    );

    // 1/(1+e) style quotients and Gaussian products
    nnad_recip u_recip
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (exp_vld),
        .in_rdy   (exp_rdy),
        .e        (exp_e),
        .side_in  (exp_side),
        .out_vld  (div_vld),
        .out_rdy  (div_rdy),
        .m        (div_m),
        .side_out (div_side)
    );

    // final select, clamp, output register
    nnad_post u_post
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (div_vld),
        .in_rdy       (div_rdy),
        .m            (div_m),
        .side         (div_side),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .y            (y),
        .error        (error)
    );

`ifndef NO_ASSERTIONS
    // unknown code returns zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error) |-> (y == '0))
        else $error("error beat with nonzero y");

    // input backs up only behind a blocked result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stalled while output free");

    // quotient never exceeds 1.0
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld |-> (div_m <= Q_W'(ONE)))
        else $error("divider quotient out of range");
`endif

endmodule

FILE: hw/rtl/nnad_exp.sv
module nnad_exp import nnad_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  logic                         action,
    input  logic [2:0]                   function_code,
    input  logic signed [DATA_WIDTH-1:0] x,
    output logic                         out_vld,
    input  logic                         out_rdy,
    output exp_word_t                    e,
    output side_t                        side
);

    localparam int DW = DATA_WIDTH;

    logic r1, r2, r3;
    logic v1_reg, v2_reg, v3_reg;

    logic [ARG_BITS-1:0] t1_reg;
    logic                z1_reg;
    side_t               s1_reg;

    exp_word_t           lo2_reg;
    exp_word_t           diff2_reg;
    logic [FRAC_IDX-1:0] f2_reg;
    logic                z2_reg;
    side_t               s2_reg;

    exp_word_t           e3_reg;
    side_t               s3_reg;

    // stage 1 combinational
    func_t                  code;
    logic                   neg;
    logic [DW-1:0]          mag;
    logic [2*DW-1:0]        sq;
    logic [2*DW-1:0]        sqr;
    logic [2*DW-1:0]        t_full;
    logic                   big;
    logic signed [Y_W-1:0]  xe;
    logic signed [Y_W-1:0]  one_y;
    logic signed [Y_W-1:0]  yb;
    logic [ARG_BITS-1:0]    t1_next;
    logic                   z1_next;
    side_t                  s1_next;

    // stage 2 / 3 combinational
    logic [TBL_LOG2:0]           idx_lo;
    logic [TBL_LOG2:0]           idx_hi;
    exp_word_t                   lo2_next;
    exp_word_t                   diff2_next;
    logic [EXP_W+FRAC_IDX-1:0]   prod;
    exp_word_t                   e3_next;

    // ready chain, a stage moves when it is empty or the next one moves
    assign r3     = !v3_reg || out_rdy;
    assign r2     = !v2_reg || r3;
    assign r1     = !v1_reg || r2;
    assign in_rdy = r1;

    // stage 1: magnitude, exp argument, results of the simple functions
    always_comb
    begin
        code  = func_t'(function_code);
        neg   = x[DW-1];
        mag   = neg ? DW'(-x) : DW'(x);
        sq    = (2*DW)'(mag) * (2*DW)'(mag);
        sqr   = (sq + (2*DW)'(HALF)) >> FRAC_BITS;
        big   = mag >= DW'(4 << FRAC_BITS);
        xe    = Y_W'(x);
        one_y = Y_W'(ONE);
        case (code)
            FN_TANH:  t_full = (2*DW)'({mag, 1'b0});
            FN_GAUSS: t_full = sqr;
            default:  t_full = (2*DW)'(mag);
        endcase
        z1_next = (t_full >= (2*DW)'(1 << ARG_BITS)) || ((code == FN_GAUSS) && big);
        t1_next = t_full[ARG_BITS-1:0];
        case (code)
            FN_NULL:  yb = action ? one_y : '0;
            FN_IDENT: yb = action ? one_y : xe;
            FN_STEP:  yb = (action || neg) ? '0 : one_y;
            FN_RELU:  yb = neg ? '0 : (action ? one_y : xe);
            default:  yb = '0;
        endcase
        s1_next = '{deriv: action, code: code, neg: neg, mag: mag, ybase: yb};
    end

    // stage 2: table samples around the argument
    always_comb
    begin
        idx_lo     = {1'b0, t1_reg[ARG_BITS-1 -: TBL_LOG2]};
        idx_hi     = idx_lo + 1'b1;
        lo2_next   = EXP_ROM[idx_lo];
        diff2_next = EXP_ROM[idx_lo] - EXP_ROM[idx_hi];
    end

    // stage 3: linear interpolation
    always_comb
    begin
        prod    = (EXP_W+FRAC_IDX)'(diff2_reg) * (EXP_W+FRAC_IDX)'(f2_reg);
        e3_next = z2_reg ? '0 : lo2_reg - EXP_W'(prod >> FRAC_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_vld;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            t1_reg <= t1_next;
            z1_reg <= z1_next;
            s1_reg <= s1_next;
        end
        if (r2)
        begin
            lo2_reg   <= lo2_next;
            diff2_reg <= diff2_next;
            f2_reg    <= t1_reg[FRAC_IDX-1:0];
            z2_reg    <= z1_reg;
            s2_reg    <= s1_reg;
        end
        if (r3)
        begin
            e3_reg <= e3_next;
            s3_reg <= s2_reg;
        end
    end

    assign out_vld = v3_reg;
    assign e       = e3_reg;
    assign side    = s3_reg;

endmodule

FILE: hw/rtl/nnad_recip.sv
module nnad_recip import nnad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    output logic             in_rdy,
    input  exp_word_t        e,
    input  side_t            side_in,
    output logic             out_vld,
    input  logic             out_rdy,
    output logic [Q_W-1:0]   m,
    output side_t            side_out
);

    localparam int GW = DATA_WIDTH + EXP_W + 2;

    logic [NUM_W-1:0] rem_reg  [0:Q_W];
    logic [EXP_W:0]   den_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    side_t            side_reg [0:Q_W];
    logic             vld_reg  [0:Q_W];
    logic [Q_W:0]     rdy;

    logic [EXP_W:0]        den;
    logic [NUM_W-1:0]      half;
    logic [NUM_W-1:0]      num;
    logic [GW-1:0]         pg;
    logic [GW-1:0]         mg;
    exp_word_t             gf;
    side_t                 side_next;

    // setup: denominator 1+e, rounded dividend, Gaussian in parallel
    always_comb
    begin
        den  = (EXP_W+1)'(Q32_ONE) + (EXP_W+1)'(e);
        half = NUM_W'(den >> 1);
        case (side_in.code)
            FN_SIGM: num = (NUM_W'(1) << (32 + FRAC_BITS)) + half;
            FN_TANH: num = (NUM_W'(Q32_ONE - e) << FRAC_BITS) + half;
            default: num = '0;
        endcase
        pg        = (GW'(side_in.mag) * GW'(e)) << 1;
        mg        = (pg + (GW'(1) << 31)) >> 32;
        gf        = (e + EXP_W'(1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        side_next = side_in;
        if (side_in.code == FN_GAUSS)
        begin
            if (side_in.deriv)
                side_next.ybase = side_in.neg ? Y_W'(mg) : -Y_W'(mg);
            else
                side_next.ybase = Y_W'(gf);
        end
    end

    assign rdy[Q_W] = !vld_reg[Q_W] || out_rdy;
    assign in_rdy   = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (rdy[0])
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            side_reg[0] <= side_next;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar s = 0; s < Q_W; s++)
    begin : g_div
        localparam int BIT = Q_W - 1 - s;
        logic [NUM_W-1:0] dsh;
        logic             take;

        assign rdy[s] = !vld_reg[s] || rdy[s+1];
        assign dsh    = NUM_W'(den_reg[s]) << BIT;
        assign take   = rem_reg[s] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (rdy[s+1])
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s+1])
            begin
                rem_reg[s+1]  <= take ? rem_reg[s] - dsh : rem_reg[s];
                den_reg[s+1]  <= den_reg[s];
                q_reg[s+1]    <= q_reg[s] | (Q_W'(take) << BIT);
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_vld  = vld_reg[Q_W];
    assign m        = q_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule

FILE: hw/rtl/nnad_post.sv
module nnad_post import nnad_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  logic [Q_W-1:0]               m,
    input  side_t                        side,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] y,
    output logic                         error
);

    localparam logic signed [Y_W-1:0] MAX_Y = Y_W'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [Y_W-1:0] MIN_Y = -MAX_Y - Y_W'(1);

    logic                          vld_reg;
    logic signed [DATA_WIDTH-1:0]  y_reg;
    logic                          err_reg;

    logic [Q_W-1:0]         one_q;
    logic [Q_W-1:0]         sv;
    logic [2*Q_W-1:0]       ps;
    logic [2*Q_W-1:0]       pm;
    logic [2*Q_W-1:0]       sig_d;
    logic [2*Q_W-1:0]       tsq;
    logic signed [Y_W-1:0]  yv;
    logic signed [DATA_WIDTH-1:0] y_next;

    // logistic and tanh from the quotient, other functions from ybase, then clamp
    always_comb
    begin
        one_q = Q_W'(ONE);
        sv    = side.neg ? one_q - m : m;
        ps    = (2*Q_W)'(sv) * (2*Q_W)'(one_q - sv);
        pm    = (2*Q_W)'(m) * (2*Q_W)'(m);
        sig_d = (ps + (2*Q_W)'(HALF)) >> FRAC_BITS;
        tsq   = (pm + (2*Q_W)'(HALF)) >> FRAC_BITS;
        case (side.code)
            FN_SIGM: yv = side.deriv ? Y_W'(sig_d) : Y_W'(sv);
            FN_TANH:
            begin
                if (side.deriv)
                    yv = Y_W'(ONE) - Y_W'(tsq);
                else
                    yv = side.neg ? -Y_W'(m) : Y_W'(m);
            end
            default: yv = side.ybase;
        endcase
        if (yv > MAX_Y)
            y_next = DATA_WIDTH'(MAX_Y);
        else if (yv < MIN_Y)
            y_next = DATA_WIDTH'(MIN_Y);
        else
            y_next = DATA_WIDTH'(yv);
    end

    assign in_rdy = !vld_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_rdy)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            y_reg   <= y_next;
            err_reg <= side.code == FN_BAD;
        end
    end

    assign result_valid = vld_reg;
    assign y            = y_reg;
    assign error        = err_reg;

endmodule

FILE: tb/sv/nn_activation_and_derivative_top_test.sv
`timescale 1ns / 1ps

module nn_activation_and_derivative_top_test import nnad_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] y;
        logic                         error;
    } act_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    logic                         action;
    logic [2:0]                   function_code;
    logic signed [DATA_WIDTH-1:0] x;
    logic                         result_valid;
    logic                         result_stall;
    logic signed [DATA_WIDTH-1:0] y;
    logic                         error;

    act_result_t expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    logic [63:0] exp_table [0:TABLE_DEPTH];

    nn_activation_and_derivative_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .function_code(function_code),
        .x            (x),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .y            (y),
        .error        (error)
    );

    always #6 clk = ~clk;

    // exp(-16k/TABLE_DEPTH) table in Q32, built by series and repeated products
    function automatic void build_exp_table();
        logic [63:0] stp;
        logic [63:0] term;
        logic [63:0] sum;
        stp  = (64'd1 << (32 + SPAN_LOG2)) / 64'(TABLE_DEPTH);
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        for (int n = 1; n < 40 && term != 0; n++)
        begin
            term = ((term * stp) >> 32) / 64'(n);
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        exp_table[0] = 64'd1 << 32;
        for (int k = 1; k <= TABLE_DEPTH; k++)
            exp_table[k] = (exp_table[k-1] * sum + (64'd1 << 31)) >> 32;
    endfunction

    function automatic logic [63:0] round_shift(logic [63:0] v, int s);
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // exp(-t) in Q32, t unsigned with FRAC_BITS fraction bits
    function automatic logic [63:0] exp_neg_q32(logic [63:0] t);
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        if (t >= (64'd1 << (FRAC_BITS + SPAN_LOG2)))
            return 64'd0;
        pos  = t * TABLE_DEPTH;
        idx  = pos >> (FRAC_BITS + SPAN_LOG2);
        frac = pos & ((64'd1 << (FRAC_BITS + SPAN_LOG2)) - 1);
        lo   = exp_table[idx];
        hi   = exp_table[idx + 1];
        return lo - (((lo - hi) * frac) >> (FRAC_BITS + SPAN_LOG2));
    endfunction

    function automatic act_result_t predict_activation(logic deriv, func_t code,
                                                       logic signed [DATA_WIDTH-1:0] xin);
        act_result_t r;
        longint      one;
        longint      xv;
        longint      yv;
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] m;
        logic        neg;
        one = longint'(1) << FRAC_BITS;
        xv  = xin;
        neg = xv < 0;
        mag = neg ? -xv : xv;
        yv  = 0;
        r.error = 1'b0;
        case (code)
            FN_NULL:  yv = deriv ? one : 0;
            FN_IDENT: yv = deriv ? one : xv;
            FN_STEP:  yv = deriv ? 0 : (neg ? 0 : one);
            FN_SIGM:
            begin
                e   = exp_neg_q32(mag);
                den = (64'd1 << 32) + e;
                m   = ((64'd1 << (FRAC_BITS + 32)) + den / 2) / den;
                yv  = neg ? one - longint'(m) : longint'(m);
                if (deriv)
                    yv = longint'(round_shift(yv * (one - yv), FRAC_BITS));
            end
            FN_TANH:
            begin
                e   = exp_neg_q32(2 * mag);
                den = (64'd1 << 32) + e;
                m   = ((((64'd1 << 32) - e) << FRAC_BITS) + den / 2) / den;
                if (deriv)
                    yv = one - longint'(round_shift(m * m, FRAC_BITS));
                else
                    yv = neg ? -longint'(m) : longint'(m);
            end
            FN_RELU:  yv = neg ? 0 : (deriv ? one : xv);
            FN_GAUSS:
            begin
                if (mag >= (64'd4 << FRAC_BITS))
                    e = 0;
                else
                    e = exp_neg_q32(round_shift(mag * mag, FRAC_BITS));
                if (deriv)
                begin
                    m  = round_shift(2 * mag * e, 32);
                    yv = neg ? longint'(m) : -longint'(m);
                end
                else
                    yv = longint'(round_shift(e, 32 - FRAC_BITS));
            end
            default:
            begin
                yv      = 0;
                r.error = 1'b1;
            end
        endcase
        if (yv > 32767)
            yv = 32767;
        else if (yv < -32768)
            yv = -32768;
        r.y = yv[DATA_WIDTH-1:0];
        return r;
    endfunction

    // Send one beat, holding it until accepted; valid drops only while idling
    task automatic send_item(logic deriv, logic [2:0] code, logic signed [DATA_WIDTH-1:0] xin);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        action        <= deriv;
        function_code <= code;
        x             <= xin;
        expected_results.push_back(predict_activation(deriv, func_t'(code), xin));
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            act_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat y=%0d error=%0b", y, error);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.y !== y || want.error !== error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected y=%0d error=%0b, got y=%0d error=%0b",
                                 want.y, want.error, y, error);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** nn_activation_and_derivative_top: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [DATA_WIDTH-1:0] corner [6] = '{16'sh8000, 16'sh7fff, 0, -1, 1, 16'sh1000};
        for (int c = 0; c < 8; c++)
            for (int d = 0; d < 2; d++)
                send_item(d[0], c[2:0], corner[(c + d) % 6]);
        // Large arguments, the Gaussian cutoff, and small step and ReLU inputs
        send_item(1'b0, FN_GAUSS, 16'sh4000);
        send_item(1'b1, FN_GAUSS, -16'sh3fff);
        send_item(1'b0, FN_SIGM, 16'sh7fff);
        send_item(1'b1, FN_TANH, 16'sh8000);
        send_item(1'b0, FN_STEP, -1);
        send_item(1'b1, FN_RELU, 0);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic signed [DATA_WIDTH-1:0] xr;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            // Mostly arguments in the interesting [-4,4) range
            if ($urandom_range(3) == 0)
                xr = DATA_WIDTH'($urandom);
            else
                xr = $signed(16'($urandom_range(65535))) >>> 1;
            send_item(1'($urandom_range(1)), 3'($urandom_range(7)), xr);
        end
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        action             = 1'b0;
        function_code      = FN_NULL;
        x                  = '0;
        result_stall       = 1'b0;
        mismatch_count     = 0;
        idle_cycles        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        build_exp_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(125, 0, 0);
        test_random(125, 71, 0);
        test_random(125, 0, 71);
        test_random(125, 18, 18);
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** nn_activation_and_derivative_top: PASSED **");
        else
            $display("** nn_activation_and_derivative_top: FAILED **");
        $finish;
    end

endmodule
